/* rtl/dgkf_pkg.sv */
// Shared widths, reset values, constants and codes of the delay gradient Kalman filter.
package dgkf_pkg;

    // Port widths
    localparam int DV_W      = 32;   // delay variation / estimate, signed Q15.16
    localparam int VAR_W     = 48;   // noise variance, unsigned Q32.16
    localparam int COV_W     = 32;   // error covariance, unsigned Q16.16
    localparam int ALPHA_W   = 25;   // EMA weight, unsigned Q1.24
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Internal widths
    localparam int AZ_W   = 33;      // |innovation|
    localparam int EQ_W   = 33;      // error_cov + q, exact
    localparam int K_W    = 31;      // gain, Q1.30 up to 1.0
    localparam int MUL_W  = 33;      // shared multiplier operand
    localparam int PROD_W = 66;
    localparam int SQ_W   = 64;      // square root radicand
    localparam int SQ16_W = 49;      // clamped innovation squared, Q.16
    localparam int ACC_W  = 51;      // blend partial sums
    localparam int DEN_W  = 49;      // variance + eq
    localparam int NUM_W  = 64;      // divider numerator
    localparam int QLO_W  = 31;      // numerator bits shifted in by the divider
    localparam int CNT_W  = 5;

    // Reset values
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 25'd16775538;
    localparam logic [COV_W-1:0]   Q_RST     = 32'd66;
    localparam logic [COV_W-1:0]   COV_RST   = 32'd6554;
    localparam logic [VAR_W-1:0]   VAR_ONE   = 48'd65536;
    localparam logic [VAR_W-1:0]   VAR_MAX   = 48'hFFFF_FFFF_FFFF;

    // Fixed-point constants
    localparam logic [ALPHA_W-1:0] ONE_Q24   = 25'h100_0000;
    localparam logic [ACC_W-1:0]   HALF_Q24  = 51'd8388608;
    localparam logic [K_W-1:0]     ONE_Q30   = 31'h4000_0000;
    localparam logic [PROD_W-1:0]  HALF_Q30  = 66'd536870912;
    localparam logic [PROD_W-1:0]  HALF_Q16  = 66'd32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_NOISE_Q = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ERR_COV  = 2'd2;

    // Request codes
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_INIT   = 1'b1;

endpackage

/* rtl/delay_gradient_kalman_filter_unit.sv */
// Scalar Kalman filter tracking the queuing-delay gradient, one word at a time.
// An update word runs the 32-step square root and the 31-step restoring divider, which share
// one subtractor, plus seven passes through the shared 33x33 multiplier; an init word goes
// straight to the output word. A new word is taken only once the last one has been loaded
// into the output word: in_stall stays high while a word is in flight.
// Reset (async, rst_n low): configuration to defaults, estimate 0, covariance 6554, variance 1.0.
module delay_gradient_kalman_filter_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [dgkf_pkg::DV_W-1:0]     delay_variation,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dgkf_pkg::DV_W-1:0]     gradient_estimate,
    output logic        [dgkf_pkg::VAR_W-1:0]    noise_variance,
    output logic                                 outlier_clamped,
    // configuration write port
    input  logic                                 cfg_write_en,
    input  logic        [dgkf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [dgkf_pkg::CFG_W-1:0]    cfg_data
);
    import dgkf_pkg::*;

    // Sequencer: square root, clamp, blend of the variance EMA, divide for the gain,
    // then estimate and covariance updates.
    typedef enum logic [4:0] {
        S_IDLE,
        S_SQRT,     // sigma = isqrt(var << 16), one result bit per cycle
        S_CLAMP,    // three-sigma clamp of |z|
        S_SQ,       // issue ac * ac
        S_MXH,      // sq16 from product; issue var_hi * a
        S_MXL,      // hi = product; issue var_lo * a
        S_MYH,      // lo = product; issue sq16_hi * b
        S_MYL,      // hi += product; issue sq16_lo * b
        S_VAR,      // lo += product + rounding half
        S_VARFIN,   // new variance with floor and ceiling; eq = cov + q
        S_DEN,      // den = var + eq
        S_NUM,      // numerator, divider setup
        S_DIV,      // restoring divide, one quotient bit per cycle
        S_KCLAMP,   // gain limited to 1.0
        S_MAG,      // issue |z| * k
        S_ECOV,     // magnitude from product; issue (1 - k) * eq
        S_EST,      // estimate and covariance written back
        S_DONE      // load output word
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] cnt_reg;

    // configuration
    logic [ALPHA_W-1:0] ema_alpha_reg;
    logic [COV_W-1:0]   state_noise_q_reg;
    logic [COV_W-1:0]   initial_error_cov_reg;

    // filter state
    logic signed [DV_W-1:0] estimate_reg;
    logic [COV_W-1:0]       error_cov_reg;
    logic [VAR_W-1:0]       noise_var_reg;

    // output word
    logic                   out_valid_reg;
    logic signed [DV_W-1:0] out_est_reg;
    logic [VAR_W-1:0]       out_var_reg;
    logic                   out_flag_reg;

    // datapath scratch
    logic [AZ_W-1:0]   az_reg;
    logic              neg_reg;
    logic              flag_reg;
    logic [SQ_W-1:0]   sq_v_reg;
    logic [SQ_W-1:0]   sq_r_reg;
    logic [AZ_W-1:0]   ac_reg;
    logic [PROD_W-1:0] p_reg;
    logic [SQ16_W-1:0] sq16_reg;
    logic [ACC_W-1:0]  hi_reg;
    logic [ACC_W-1:0]  lo_reg;
    logic [EQ_W-1:0]   eq_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QLO_W-1:0]  num_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [K_W-1:0]    q_reg;
    logic [K_W-1:0]    k_reg;
    logic [AZ_W-1:0]   mag_reg;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic              in_accept;
    logic              out_take;
    logic              out_load;
    logic [AZ_W-1:0]   z_diff;
    logic [AZ_W-1:0]   z_abs;
    logic [ALPHA_W-1:0] a_sat;
    logic [ALPHA_W-1:0] b_w;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // innovation z = d - estimate, 33-bit signed, and its magnitude
    assign z_diff = {delay_variation[DV_W-1], delay_variation}
                  - {estimate_reg[DV_W-1], estimate_reg};
    assign z_abs  = z_diff[AZ_W-1] ? (~z_diff + AZ_W'(1)) : z_diff;

    // alpha above one acts as one
    assign a_sat = (ema_alpha_reg > ONE_Q24) ? ONE_Q24 : ema_alpha_reg;
    assign b_w   = ONE_Q24 - a_sat;

    // shared multiplier: operands chosen by state, product registered
    logic [MUL_W-1:0] mul_a;
    logic [MUL_W-1:0] mul_b;

    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = ac_reg;
                mul_b = ac_reg;
            end
            S_MXH:
            begin
                mul_a = MUL_W'(noise_var_reg[VAR_W-1:24]);
                mul_b = MUL_W'(a_sat);
            end
            S_MXL:
            begin
                mul_a = MUL_W'(noise_var_reg[23:0]);
                mul_b = MUL_W'(a_sat);
            end
            S_MYH:
            begin
                mul_a = MUL_W'(sq16_reg[SQ16_W-1:24]);
                mul_b = MUL_W'(b_w);
            end
            S_MYL:
            begin
                mul_a = MUL_W'(sq16_reg[23:0]);
                mul_b = MUL_W'(b_w);
            end
            S_MAG:
            begin
                mul_a = az_reg;
                mul_b = MUL_W'(k_reg);
            end
            S_ECOV:
            begin
                mul_a = MUL_W'(ONE_Q30 - k_reg);
                mul_b = eq_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared subtractor: square root trial and divider trial
    logic [SQ_W-1:0] sq_bit;
    logic [SQ_W-1:0] sub_x;
    logic [SQ_W-1:0] sub_y;
    logic [SQ_W:0]   sub_diff;
    logic            sub_ge;
    logic [DEN_W:0]  div_x;

    // r and bit never overlap, so r + bit is r | bit
    assign sq_bit = SQ_W'(1) << {cnt_reg, 1'b0};
    assign div_x  = {rem_reg, num_reg[QLO_W-1]};

    always_comb
    begin
        case (state_reg)
            S_SQRT:
            begin
                sub_x = sq_v_reg;
                sub_y = sq_r_reg | sq_bit;
            end
            S_DIV:
            begin
                sub_x = SQ_W'(div_x);
                sub_y = SQ_W'(den_reg);
            end
            default:
            begin
                sub_x = '0;
                sub_y = '0;
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
    assign sub_ge   = !sub_diff[SQ_W];

    // three sigma and the clamp
    logic [AZ_W:0] thr;
    logic          clamp_hit;

    assign thr       = {2'b00, sq_r_reg[31:0]} + {1'b0, sq_r_reg[31:0], 1'b0};
    assign clamp_hit = {1'b0, az_reg} > thr;

    // variance blend result, floor 1.0, ceiling 48 bits
    logic [ACC_W:0]   var_sum;
    logic [VAR_W-1:0] var_new;

    assign var_sum = {1'b0, hi_reg} + (ACC_W + 1)'(lo_reg[ACC_W-1:24]);

    always_comb
    begin
        if (var_sum < (ACC_W + 1)'(VAR_ONE))
            var_new = VAR_ONE;
        else if (var_sum > (ACC_W + 1)'(VAR_MAX))
            var_new = VAR_MAX;
        else
            var_new = var_sum[VAR_W-1:0];
    end

    // divider numerator: (eq << 30) + den / 2
    logic [NUM_W-1:0] num_sum;

    assign num_sum = NUM_W'({eq_reg, 30'b0}) + NUM_W'(den_reg[DEN_W-1:1]);

    // rounded product terms
    logic [PROD_W-1:0] p_round16;
    logic [PROD_W-1:0] p_round30;

    assign p_round16 = p_reg + HALF_Q16;
    assign p_round30 = p_reg + HALF_Q30;

    // estimate update with saturation
    localparam logic signed [DV_W+2:0] EST_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [DV_W+2:0] EST_MIN = 35'sh7_8000_0000;

    logic signed [DV_W+2:0] est_ext;
    logic signed [DV_W+2:0] mag_ext;
    logic signed [DV_W+2:0] est_sum;
    logic signed [DV_W-1:0] est_new;

    assign est_ext = {{3{estimate_reg[DV_W-1]}}, estimate_reg};
    assign mag_ext = {2'b00, mag_reg};
    assign est_sum = neg_reg ? (est_ext - mag_ext) : (est_ext + mag_ext);

    always_comb
    begin
        if (est_sum > EST_MAX)
            est_new = EST_MAX[DV_W-1:0];
        else if (est_sum < EST_MIN)
            est_new = EST_MIN[DV_W-1:0];
        else
            est_new = est_sum[DV_W-1:0];
    end

    // covariance update with saturation; p_round30 >> 30 fits 36 bits
    logic [COV_W-1:0] cov_new;

    assign cov_new = (p_round30[PROD_W-1:30] > 36'(32'hFFFF_FFFF))
                   ? 32'hFFFF_FFFF : p_round30[30+COV_W-1:30];

    // ------------------------------------------------------------------
    // Sequencer, configuration, filter state and output word
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            cnt_reg               <= '0;
            ema_alpha_reg         <= ALPHA_RST;
            state_noise_q_reg     <= Q_RST;
            initial_error_cov_reg <= COV_RST;
            estimate_reg          <= '0;
            error_cov_reg         <= COV_RST;
            noise_var_reg         <= VAR_ONE;
            out_valid_reg         <= 1'b0;
            out_est_reg           <= '0;
            out_var_reg           <= '0;
            out_flag_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_EMA_ALPHA:     ema_alpha_reg         <= cfg_data[ALPHA_W-1:0];
                    CFG_STATE_NOISE_Q: state_noise_q_reg     <= cfg_data;
                    CFG_INIT_ERR_COV:  initial_error_cov_reg <= cfg_data;
                    default:           ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_est_reg   <= estimate_reg;
                out_var_reg   <= noise_var_reg;
                out_flag_reg  <= flag_reg;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (req_type == REQ_INIT)
                        begin
                            estimate_reg  <= '0;
                            error_cov_reg <= initial_error_cov_reg;
                            noise_var_reg <= VAR_ONE;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            cnt_reg   <= CNT_W'(31);
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                        state_reg <= S_CLAMP;
                end
                S_CLAMP:  state_reg <= S_SQ;
                S_SQ:     state_reg <= S_MXH;
                S_MXH:    state_reg <= S_MXL;
                S_MXL:    state_reg <= S_MYH;
                S_MYH:    state_reg <= S_MYL;
                S_MYL:    state_reg <= S_VAR;
                S_VAR:    state_reg <= S_VARFIN;
                S_VARFIN:
                begin
                    noise_var_reg <= var_new;
                    state_reg     <= S_DEN;
                end
                S_DEN:    state_reg <= S_NUM;
                S_NUM:
                begin
                    cnt_reg   <= CNT_W'(30);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                        state_reg <= S_KCLAMP;
                end
                S_KCLAMP: state_reg <= S_MAG;
                S_MAG:    state_reg <= S_ECOV;
                S_ECOV:   state_reg <= S_EST;
                S_EST:
                begin
                    estimate_reg  <= est_new;
                    error_cov_reg <= cov_new;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    az_reg   <= z_abs;
                    neg_reg  <= z_diff[AZ_W-1];
                    flag_reg <= 1'b0;
                    sq_v_reg <= {noise_var_reg, 16'b0};
                    sq_r_reg <= '0;
                end
            end
            S_SQRT:
            begin
                if (sub_ge)
                begin
                    sq_v_reg <= sub_diff[SQ_W-1:0];
                    sq_r_reg <= (sq_r_reg >> 1) | sq_bit;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
            end
            S_CLAMP:
            begin
                flag_reg <= clamp_hit;
                ac_reg   <= clamp_hit ? thr[AZ_W-1:0] : az_reg;
            end
            S_MXH:    sq16_reg <= p_round16[16+SQ16_W-1:16];
            S_MXL:    hi_reg   <= p_reg[ACC_W-1:0];
            S_MYH:    lo_reg   <= p_reg[ACC_W-1:0];
            S_MYL:    hi_reg   <= hi_reg + p_reg[ACC_W-1:0];
            S_VAR:    lo_reg   <= lo_reg + p_reg[ACC_W-1:0] + HALF_Q24;
            S_VARFIN: eq_reg   <= {1'b0, error_cov_reg} + {1'b0, state_noise_q_reg};
            S_DEN:    den_reg  <= {1'b0, noise_var_reg} + DEN_W'(eq_reg);
            S_NUM:
            begin
                rem_reg <= DEN_W'(num_sum[NUM_W-1:QLO_W]);
                num_reg <= num_sum[QLO_W-1:0];
                q_reg   <= '0;
            end
            S_DIV:
            begin
                rem_reg <= sub_ge ? sub_diff[DEN_W-1:0] : div_x[DEN_W-1:0];
                num_reg <= num_reg << 1;
                q_reg   <= {q_reg[K_W-2:0], sub_ge};
            end
            S_KCLAMP: k_reg   <= (q_reg > ONE_Q30) ? ONE_Q30 : q_reg;
            S_ECOV:   mag_reg <= p_round30[30+AZ_W-1:30];
            default:  ;
        endcase
    end

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign gradient_estimate = out_est_reg;
    assign noise_variance    = out_var_reg;
    assign outlier_clamped   = out_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_var_floor: assert property (@(posedge clk) disable iff (!rst_n)
        noise_var_reg >= VAR_ONE)
        else $error("noise variance below 1.0");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAG) |-> (k_reg <= ONE_Q30))
        else $error("Kalman gain above 1.0");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result word loaded over a pending word");

endmodule
